FILE: rtl/core/gcd_pkg.sv
// Shared types, constants and tables of the great-circle distance core.
`default_nettype none
package gcd_pkg;

   // Default number of CORDIC iterations per trig unit
   localparam int CORDIC_STAGES_DEFAULT = 24;

   // Datapath widths
   localparam int DEG_W   = 26;   // degree difference, 16 fraction bits
   localparam int ANGLE_W = 32;   // binary angle, full turn = 2^32
   localparam int CORD_W  = 34;   // CORDIC x, y and residual angle
   localparam int SQRT_W  = 62;   // square root remainder and root
   localparam int DIST_W  = 29;   // distance, 8 fraction bits
   localparam int RAD_W   = 16;   // sphere radius in km

   // Fixed-point constants
   localparam logic [33:0] GAIN_Q30   = 34'd652032874;
   localparam logic [30:0] ONE_Q30    = 31'h4000_0000;
   localparam logic [31:0] TWO_PI_Q29 = 32'd3373259426;
   localparam logic [26:0] RECIP_45   = 27'd95443718;   // ceil(2^32 / 45)
   localparam logic [RAD_W-1:0] RADIUS_RESET = 16'd6371;

   // Register index of the radius register
   localparam logic [0:0] CSR_IDX_RADIUS = 1'b0;

   // Arctangent of 2^-i as binary angle
   localparam logic [31:0] ATAN_BIN [32] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
      32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
      32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
      32'd166886,    32'd83443,     32'd41722,     32'd20861,
      32'd10430,     32'd5215,      32'd2608,      32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81,
      32'd41,        32'd20,        32'd10,        32'd5,
      32'd3,         32'd1,         32'd1,         32'd0
   };

   // Data handed from one rotation cell to the next
   typedef struct packed {
      logic [CORD_W-1:0] x;
      logic [CORD_W-1:0] y;
      logic [CORD_W-1:0] t;
      logic              flip;
   } rot_type;

   // Data handed from one vectoring cell to the next
   typedef struct packed {
      logic [CORD_W-1:0] x;
      logic [CORD_W-1:0] y;
      logic [CORD_W-1:0] z;
   } vec_type;

   // Data handed from one square root cell to the next
   typedef struct packed {
      logic [SQRT_W-1:0] rem;
      logic [SQRT_W-1:0] root;
   } sqrt_type;

endpackage
`default_nettype wire

FILE: rtl/core/great_circle_distance_core.sv
// Top level: great-circle distance pipeline with CSR port and output skid.
// Throughput: one request per cycle while req_stall is low; the chains of CORDIC and square
// root cells each take a new operand every cycle that the pipeline advances.
// A two-entry output (register plus skid) lets one result wait before req_stall rises.
// Reset (synchronous) empties the pipeline and sets the radius to 6371 km.
`default_nettype none
module great_circle_distance_core #(
   parameter int CORDIC_STAGES = gcd_pkg::CORDIC_STAGES_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   // request channel
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic signed [23:0]           req_origin_lat,
   input  wire logic signed [24:0]           req_origin_lon,
   input  wire logic signed [23:0]           req_dest_lat,
   input  wire logic signed [24:0]           req_dest_lon,
   // result channel
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic [gcd_pkg::DIST_W-1:0]        rsp_distance_km,
   // configuration port
   input  wire logic                         csr_psel,
   input  wire logic                         csr_penable,
   input  wire logic                         csr_pwrite,
   input  wire logic [2:0]                   csr_paddr,
   input  wire logic [31:0]                  csr_pwdata,
   output logic [31:0]                       csr_prdata,
   output logic                              csr_pready
);

   localparam int PIPE_DEPTH = 2 * CORDIC_STAGES + 43;
   localparam int SQRT_STEPS = 31;
   localparam int CW = gcd_pkg::CORD_W;
   localparam logic signed [CW-1:0] HALF_TURN    = CW'(64'h8000_0000);
   localparam logic signed [CW-1:0] QUARTER_TURN = CW'(64'h4000_0000);

   logic                       pipe_adv;
   logic [PIPE_DEPTH-1:0]      valid_ff;
   logic [gcd_pkg::RAD_W-1:0]  radius_ff;
   logic                       csr_write;

   logic signed [gcd_pkg::DEG_W-1:0] deg [4];
   logic [3:0]                       half_sel;
   logic [gcd_pkg::ANGLE_W-1:0]      angle [4];
   gcd_pkg::rot_type                 fold_ff [4];
   gcd_pkg::rot_type                 rot_chain [4][CORDIC_STAGES];
   logic signed [CW-1:0]             cos_val [4];
   logic signed [CW-1:0]             sin_val [4];

   logic signed [67:0]  sa_sq, sb_sq, cc_prod, p_in;
   logic signed [CW-1:0] sa2_ff, sb2_ff, cc_ff, sa2_d_ff;
   logic signed [67:0]  p_ff;
   logic signed [CW:0]  h_sum;
   logic [30:0]         h_ff, h_in;

   gcd_pkg::sqrt_type   sqrt_init [2];
   gcd_pkg::sqrt_type   sqrt_chain [2][SQRT_STEPS];
   gcd_pkg::vec_type    vec_init;
   gcd_pkg::vec_type    vec_chain [CORDIC_STAGES];

   logic signed [CW-1:0] z_last;
   logic [30:0]          z_clamp;
   logic [47:0]          prod_ff, prod_in;
   logic [58:0]          hi_ff;
   logic [52:0]          lo_full;
   logic [31:0]          lo_ff;
   logic [60:0]          dist_sum;
   logic [gcd_pkg::DIST_W-1:0] dist_round;
   logic                 tail_valid;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 skid_valid_ff, skid_valid_in;
   logic [gcd_pkg::DIST_W-1:0] rsp_dist_ff, rsp_dist_in;
   logic [gcd_pkg::DIST_W-1:0] skid_dist_ff, skid_dist_in;
   logic                 out_take;

   // Advance the whole pipeline while the skid entry is free
   assign pipe_adv  = !skid_valid_ff;
   assign req_stall = skid_valid_ff;

   // Track valid requests through the pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (pipe_adv) begin
         valid_ff <= {valid_ff[PIPE_DEPTH-2:0], req_valid};
      end
   end

   // Radius register
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2:2] == gcd_pkg::CSR_IDX_RADIUS) ?
                       {16'd0, radius_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= gcd_pkg::RADIUS_RESET;
      end else if (csr_write && csr_paddr[2:2] == gcd_pkg::CSR_IDX_RADIUS) begin
         radius_ff <= csr_pwdata[15:0];
      end
   end

   function automatic logic signed [gcd_pkg::DEG_W-1:0] DEG_W_EXT_LAT(
      input logic signed [23:0] v
   );
      return {{2{v[23]}}, v};
   endfunction

   // Degree operands: both latitudes, half latitude and longitude differences
   always_comb begin
      deg[0] = DEG_W_EXT_LAT(req_origin_lat);
      deg[1] = DEG_W_EXT_LAT(req_dest_lat);
      deg[2] = DEG_W_EXT_LAT(req_dest_lat) - DEG_W_EXT_LAT(req_origin_lat);
      deg[3] = {req_dest_lon[24], req_dest_lon} - {req_origin_lon[24], req_origin_lon};
      half_sel = 4'b1100;
   end

   for (genvar a = 0; a < 4; a++) begin : g_trig
      logic signed [CW-1:0] t_raw;
      gcd_pkg::rot_type     fold_in;

      gcd_angle_conv u_conv (
         .clock   (clock),
         .enable  (pipe_adv),
         .half    (half_sel[a]),
         .degrees (deg[a]),
         .angle   (angle[a])
      );

      // Fold the angle into the right half plane
      always_comb begin
         t_raw        = {{2{angle[a][31]}}, angle[a]};
         fold_in.x    = gcd_pkg::GAIN_Q30;
         fold_in.y    = '0;
         fold_in.t    = t_raw;
         fold_in.flip = 1'b0;
         if (t_raw > QUARTER_TURN) begin
            fold_in.t    = t_raw - HALF_TURN;
            fold_in.flip = 1'b1;
         end else if (t_raw < -QUARTER_TURN) begin
            fold_in.t    = t_raw + HALF_TURN;
            fold_in.flip = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (pipe_adv) begin
            fold_ff[a] <= fold_in;
         end
      end

      for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_rot
         if (k == 0) begin : g_first
            gcd_rot_cell #(.STAGE(k)) u_cell (
               .clock    (clock),
               .enable   (pipe_adv),
               .cell_in  (fold_ff[a]),
               .cell_out (rot_chain[a][k])
            );
         end else begin : g_next
            gcd_rot_cell #(.STAGE(k)) u_cell (
               .clock    (clock),
               .enable   (pipe_adv),
               .cell_in  (rot_chain[a][k-1]),
               .cell_out (rot_chain[a][k])
            );
         end
      end

      // Undo the half-turn fold
      always_comb begin
         cos_val[a] = rot_chain[a][CORDIC_STAGES-1].flip ?
                      -$signed(rot_chain[a][CORDIC_STAGES-1].x) :
                       $signed(rot_chain[a][CORDIC_STAGES-1].x);
         sin_val[a] = rot_chain[a][CORDIC_STAGES-1].flip ?
                      -$signed(rot_chain[a][CORDIC_STAGES-1].y) :
                       $signed(rot_chain[a][CORDIC_STAGES-1].y);
      end
   end

   // Squares of the half-angle sines and the cosine product
   assign sa_sq   = sin_val[2] * sin_val[2];
   assign sb_sq   = sin_val[3] * sin_val[3];
   assign cc_prod = cos_val[0] * cos_val[1];
   assign p_in    = cc_ff * sb2_ff;

   // Haversine sum, saturated to [0, 1]
   always_comb begin
      h_sum = {sa2_d_ff[CW-1], sa2_d_ff} + {p_ff[63], p_ff[63:30]};
      priority if (h_sum[CW]) begin
         h_in = '0;
      end else if (h_sum > $signed({4'd0, gcd_pkg::ONE_Q30})) begin
         h_in = gcd_pkg::ONE_Q30;
      end else begin
         h_in = h_sum[30:0];
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_adv) begin
         sa2_ff   <= sa_sq[63:30];
         sb2_ff   <= sb_sq[63:30];
         cc_ff    <= cc_prod[63:30];
         p_ff     <= p_in;
         sa2_d_ff <= sa2_ff;
         h_ff     <= h_in;
      end
   end

   // Square roots of h and 1-h, both scaled to Q30
   always_comb begin
      sqrt_init[0].rem  = gcd_pkg::SQRT_W'(gcd_pkg::ONE_Q30 - h_ff) << 30;
      sqrt_init[0].root = '0;
      sqrt_init[1].rem  = gcd_pkg::SQRT_W'(h_ff) << 30;
      sqrt_init[1].root = '0;
   end

   for (genvar r = 0; r < 2; r++) begin : g_sqrt
      for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
         if (k == 0) begin : g_first
            gcd_sqrt_cell #(.STEP(k)) u_cell (
               .clock    (clock),
               .enable   (pipe_adv),
               .cell_in  (sqrt_init[r]),
               .cell_out (sqrt_chain[r][k])
            );
         end else begin : g_next
            gcd_sqrt_cell #(.STEP(k)) u_cell (
               .clock    (clock),
               .enable   (pipe_adv),
               .cell_in  (sqrt_chain[r][k-1]),
               .cell_out (sqrt_chain[r][k])
            );
         end
      end
   end

   // Half of the central angle by vectoring on (sqrt(1-h), sqrt(h))
   always_comb begin
      vec_init.x = sqrt_chain[0][SQRT_STEPS-1].root[CW-1:0];
      vec_init.y = sqrt_chain[1][SQRT_STEPS-1].root[CW-1:0];
      vec_init.z = '0;
   end

   for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_vec
      if (k == 0) begin : g_first
         gcd_vec_cell #(.STAGE(k)) u_cell (
            .clock    (clock),
            .enable   (pipe_adv),
            .cell_in  (vec_init),
            .cell_out (vec_chain[k])
         );
      end else begin : g_next
         gcd_vec_cell #(.STAGE(k)) u_cell (
            .clock    (clock),
            .enable   (pipe_adv),
            .cell_in  (vec_chain[k-1]),
            .cell_out (vec_chain[k])
         );
      end
   end

   // Clamp the half angle, double it and scale by the radius
   always_comb begin
      z_last = $signed(vec_chain[CORDIC_STAGES-1].z);
      priority if (z_last[CW-1]) begin
         z_clamp = '0;
      end else if (z_last > $signed({3'd0, gcd_pkg::ONE_Q30})) begin
         z_clamp = gcd_pkg::ONE_Q30;
      end else begin
         z_clamp = z_last[30:0];
      end
      prod_in = 48'({z_clamp, 1'b0}) * 48'(radius_ff);
   end

   // Multiply by 2*pi in two partial products
   assign lo_full = 53'(prod_ff[20:0]) * 53'(gcd_pkg::TWO_PI_Q29);

   always_ff @(posedge clock) begin
      if (pipe_adv) begin
         prod_ff <= prod_in;
         hi_ff   <= 59'(prod_ff[47:21]) * 59'(gcd_pkg::TWO_PI_Q29);
         lo_ff   <= lo_full[52:21];
      end
   end

   // Round to 8 fraction bits
   assign dist_sum   = 61'(hi_ff) + 61'(lo_ff) + (61'(1) << 31);
   assign dist_round = dist_sum[60:32];
   assign tail_valid = valid_ff[PIPE_DEPTH-1];

   // Output register and skid entry
   always_comb begin
      out_take      = rsp_valid_ff && !rsp_stall;
      rsp_valid_in  = rsp_valid_ff;
      skid_valid_in = skid_valid_ff;
      rsp_dist_in   = rsp_dist_ff;
      skid_dist_in  = skid_dist_ff;
      priority if (skid_valid_ff) begin
         if (out_take) begin
            rsp_dist_in   = skid_dist_ff;
            skid_valid_in = 1'b0;
         end
      end else if (!rsp_valid_ff || out_take) begin
         rsp_valid_in = tail_valid;
         rsp_dist_in  = dist_round;
      end else begin
         skid_valid_in = tail_valid;
         skid_dist_in  = dist_round;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_dist_ff  <= rsp_dist_in;
      skid_dist_ff <= skid_dist_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_distance_km = rsp_dist_ff;

   // A held result in the skid always has one in front of it
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid entry valid without output result");

   // A result reaching a blocked output lands in the skid
   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall && !skid_valid_ff && tail_valid) |=> skid_valid_ff)
      else $error("result dropped at blocked output");

   // A taken output drains the skid
   a_skid_drain: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && !rsp_stall) |=> (!skid_valid_ff && rsp_valid_ff))
      else $error("skid entry not moved to output");

   // Radius write lands in the register
   a_radius_write: assert property (@(posedge clock) disable iff (reset)
      (csr_write && csr_paddr[2:2] == gcd_pkg::CSR_IDX_RADIUS) |=>
      (radius_ff == $past(csr_pwdata[15:0])))
      else $error("radius write lost");

endmodule
`default_nettype wire

FILE: rtl/core/gcd_angle_conv.sv
// Pipelined conversion of degrees (16 fraction bits) to a binary angle.
`default_nettype none
module gcd_angle_conv (
   input  wire logic                              clock,
   input  wire logic                              enable,
   input  wire logic                              half,
   input  wire logic signed [gcd_pkg::DEG_W-1:0]  degrees,
   output logic [gcd_pkg::ANGLE_W-1:0]            angle
);

   logic [25:0] mag_ff, mag_in, mag2_ff;
   logic        neg1_ff, neg2_ff, neg3_ff, neg4_ff, neg5_ff;
   logic [20:0] q1_2_ff, q1_3_ff, q1_4_ff, q1_5_ff;
   logic [52:0] q1_full;
   logic [5:0]  r1_ff, r1_in;
   logic [21:0] x_scaled;
   logic [18:0] y_ff;
   logic [45:0] q2_full;
   logic [13:0] q2_ff;
   logic [33:0] quot;
   logic [31:0] angle_ff, angle_in;

   // Split magnitude and sign
   always_comb begin
      mag_in = degrees[gcd_pkg::DEG_W-1] ? 26'(-degrees) : 26'(degrees);
   end

   // Coarse quotient mag / 45 by reciprocal multiply
   assign q1_full = 53'(mag_ff) * 53'(gcd_pkg::RECIP_45);

   // Remainder of the coarse division
   assign r1_in = 6'(mag2_ff - 26'(27'(q1_2_ff) * 27'd45));

   // Scale remainder, add rounding, fold in the factor 8 of 360
   assign x_scaled = (22'(r1_ff) << (half ? 15 : 16)) + 22'd180;

   // Fine quotient
   assign q2_full = 46'(y_ff) * 46'(gcd_pkg::RECIP_45);

   // Combine quotients and restore the sign
   always_comb begin
      quot     = (34'(q1_5_ff) << (half ? 12 : 13)) + 34'(q2_ff);
      angle_in = neg5_ff ? 32'(-quot) : 32'(quot);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         mag_ff   <= mag_in;
         neg1_ff  <= degrees[gcd_pkg::DEG_W-1];
         q1_2_ff  <= q1_full[52:32];
         mag2_ff  <= mag_ff;
         neg2_ff  <= neg1_ff;
         r1_ff    <= r1_in;
         q1_3_ff  <= q1_2_ff;
         neg3_ff  <= neg2_ff;
         y_ff     <= x_scaled[21:3];
         q1_4_ff  <= q1_3_ff;
         neg4_ff  <= neg3_ff;
         q2_ff    <= q2_full[45:32];
         q1_5_ff  <= q1_4_ff;
         neg5_ff  <= neg4_ff;
         angle_ff <= angle_in;
      end
   end

   assign angle = angle_ff;

endmodule
`default_nettype wire

FILE: rtl/core/gcd_rot_cell.sv
// One rotation-mode CORDIC cell: a fixed micro-rotation by atan(2^-STAGE).
`default_nettype none
module gcd_rot_cell #(
   parameter int STAGE = 0
) (
   input  wire logic             clock,
   input  wire logic             enable,
   input  wire gcd_pkg::rot_type cell_in,
   output gcd_pkg::rot_type      cell_out
);

   localparam logic [gcd_pkg::CORD_W-1:0] ATAN =
      gcd_pkg::CORD_W'(gcd_pkg::ATAN_BIN[STAGE]);

   gcd_pkg::rot_type stage_ff, stage_in;
   logic signed [gcd_pkg::CORD_W-1:0] xs, ys;

   // Rotate toward zero residual angle
   always_comb begin
      xs = $signed(cell_in.x) >>> STAGE;
      ys = $signed(cell_in.y) >>> STAGE;
      stage_in.flip = cell_in.flip;
      if (!cell_in.t[gcd_pkg::CORD_W-1]) begin
         stage_in.x = cell_in.x - ys;
         stage_in.y = cell_in.y + xs;
         stage_in.t = cell_in.t - ATAN;
      end else begin
         stage_in.x = cell_in.x + ys;
         stage_in.y = cell_in.y - xs;
         stage_in.t = cell_in.t + ATAN;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         stage_ff <= stage_in;
      end
   end

   assign cell_out = stage_ff;

endmodule
`default_nettype wire

FILE: rtl/core/gcd_sqrt_cell.sv
// One step of the bit-pair integer square root: decides one root bit.
`default_nettype none
module gcd_sqrt_cell #(
   parameter int STEP = 0
) (
   input  wire logic              clock,
   input  wire logic              enable,
   input  wire gcd_pkg::sqrt_type cell_in,
   output gcd_pkg::sqrt_type      cell_out
);

   localparam logic [gcd_pkg::SQRT_W-1:0] BIT =
      gcd_pkg::SQRT_W'(1) << (60 - 2 * STEP);

   gcd_pkg::sqrt_type stage_ff, stage_in;
   logic [gcd_pkg::SQRT_W-1:0] trial;

   // Subtract the trial value where it fits
   always_comb begin
      trial = cell_in.root + BIT;
      if (cell_in.rem >= trial) begin
         stage_in.rem  = cell_in.rem - trial;
         stage_in.root = (cell_in.root >> 1) + BIT;
      end else begin
         stage_in.rem  = cell_in.rem;
         stage_in.root = cell_in.root >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         stage_ff <= stage_in;
      end
   end

   assign cell_out = stage_ff;

endmodule
`default_nettype wire

FILE: rtl/core/gcd_vec_cell.sv
// One vectoring-mode CORDIC cell: drives y toward zero, accumulates angle.
`default_nettype none
module gcd_vec_cell #(
   parameter int STAGE = 0
) (
   input  wire logic             clock,
   input  wire logic             enable,
   input  wire gcd_pkg::vec_type cell_in,
   output gcd_pkg::vec_type      cell_out
);

   localparam logic [gcd_pkg::CORD_W-1:0] ATAN =
      gcd_pkg::CORD_W'(gcd_pkg::ATAN_BIN[STAGE]);

   gcd_pkg::vec_type stage_ff, stage_in;
   logic signed [gcd_pkg::CORD_W-1:0] xs, ys;

   // Rotate by the sign of y
   always_comb begin
      xs = $signed(cell_in.x) >>> STAGE;
      ys = $signed(cell_in.y) >>> STAGE;
      if ($signed(cell_in.y) > 0) begin
         stage_in.x = cell_in.x + ys;
         stage_in.y = cell_in.y - xs;
         stage_in.z = cell_in.z + ATAN;
      end else begin
         stage_in.x = cell_in.x - ys;
         stage_in.y = cell_in.y + xs;
         stage_in.z = cell_in.z - ATAN;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         stage_ff <= stage_in;
      end
   end

   assign cell_out = stage_ff;

endmodule
`default_nettype wire

FILE: sim/tb_great_circle_distance_core.sv
// Testbench for the great-circle distance core: streams coordinate pairs and checks each distance.
`default_nettype none
module tb_great_circle_distance_core;

   localparam int  STAGES       = 24;
   localparam int  LATENCY      = 2*STAGES + 44;
   localparam int  STALL_LIMIT  = 6000;
   localparam int  PHASE_ITEMS  = 125;
   localparam int  HOLD_CYCLES  = 400;
   localparam logic [2:0] ADDR_RADIUS = 3'd0;

   localparam longint ONE_Q30 = 64'sd1 << 30;
   localparam longint GAIN    = 64'sd652032874;
   localparam longint unsigned TWO_PI = 64'd3373259426;

   localparam longint ATAN_TAB [32] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
      41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
      10, 5, 3, 1, 1, 0
   };

   typedef struct {
      logic signed [23:0] olat;
      logic signed [24:0] olon;
      logic signed [23:0] dlat;
      logic signed [24:0] dlon;
   } coord_pair_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                req_valid = 1'b0;
   logic                req_stall;
   logic signed [23:0]  req_origin_lat = '0;
   logic signed [24:0]  req_origin_lon = '0;
   logic signed [23:0]  req_dest_lat = '0;
   logic signed [24:0]  req_dest_lon = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [28:0]         rsp_distance_km;
   logic                csr_psel = 1'b0;
   logic                csr_penable = 1'b0;
   logic                csr_pwrite = 1'b0;
   logic [2:0]          csr_paddr = '0;
   logic [31:0]         csr_pwdata = '0;
   logic [31:0]         csr_prdata;
   logic                csr_pready;

   great_circle_distance_core DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_origin_lat(req_origin_lat), .req_origin_lon(req_origin_lon),
      .req_dest_lat(req_dest_lat), .req_dest_lon(req_dest_lon),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_distance_km(rsp_distance_km),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   coord_pair_type       pending_pairs [$];
   logic [28:0]          expected_dist [$];
   coord_pair_type       shown_pair;
   longint unsigned      radius_km = 6371;
   int                   send_idle_pct = 0;
   int                   recv_idle_pct = 0;
   logic                 hold_start = 1'b0;
   int                   hold_cnt = 0;
   int                   error_count = 0;
   int                   pairs_sent = 0;
   int                   dists_seen = 0;
   int                   quiet_cycles = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   // Floor shift for signed values
   function automatic longint floor_shift(longint v, int n);
      return v >>> n;
   endfunction

   // Degrees with 16 fraction bits to binary angle, scaled by 2^sh/360
   function automatic logic [31:0] degrees_to_angle(longint d, int sh);
      longint unsigned mag, q;
      mag = (d < 0) ? longint'(-d) : longint'(d);
      q = ((mag << sh) + 180) / 360;
      if (d < 0) q = 64'd0 - q;
      return q[31:0];
   endfunction

   // Cosine and sine of a binary angle in Q30
   task automatic sin_cos(input logic [31:0] ang, output longint c, output longint s);
      longint t, x, y, nx;
      bit flip;
      t = longint'({32'd0, ang});
      x = GAIN;
      y = 0;
      flip = 1'b0;
      if (t >= (64'sd1 << 31)) t -= 64'sd1 << 32;
      if (t > (64'sd1 << 30)) begin
         t -= 64'sd1 << 31;
         flip = 1'b1;
      end else if (t < -(64'sd1 << 30)) begin
         t += 64'sd1 << 31;
         flip = 1'b1;
      end
      for (int i = 0; i < STAGES; i++) begin
         if (t >= 0) begin
            nx = x - floor_shift(y, i);
            y = y + floor_shift(x, i);
            t -= ATAN_TAB[i];
         end else begin
            nx = x + floor_shift(y, i);
            y = y - floor_shift(x, i);
            t += ATAN_TAB[i];
         end
         x = nx;
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endtask

   // Binary angle of the vector (x, y)
   function automatic longint vector_phase(longint x, longint y);
      longint z, nx;
      z = 0;
      for (int i = 0; i < STAGES; i++) begin
         if (y > 0) begin
            nx = x + floor_shift(y, i);
            y = y - floor_shift(x, i);
            z += ATAN_TAB[i];
         end else begin
            nx = x - floor_shift(y, i);
            y = y + floor_shift(x, i);
            z -= ATAN_TAB[i];
         end
         x = nx;
      end
      return z;
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned n);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   // Distance in km, 8 fraction bits, for one coordinate pair
   task automatic predict_distance(input coord_pair_type p, output logic [28:0] dist_km);
      longint la1, lo1, la2, lo2, c1, c2, ca, sa, cb, sb, unused, sa2, sb2, cc, h, z;
      longint unsigned ys, xs, cbin, prod, hi, lo, d;
      la1 = p.olat; lo1 = p.olon; la2 = p.dlat; lo2 = p.dlon;
      sin_cos(degrees_to_angle(la1, 16), c1, unused);
      sin_cos(degrees_to_angle(la2, 16), c2, unused);
      sin_cos(degrees_to_angle(la2 - la1, 15), ca, sa);
      sin_cos(degrees_to_angle(lo2 - lo1, 15), cb, sb);
      sa2 = (sa * sa) >>> 30;
      sb2 = (sb * sb) >>> 30;
      cc = floor_shift(c1 * c2, 30);
      h = sa2 + floor_shift(cc * sb2, 30);
      if (h < 0) h = 0;
      if (h > ONE_Q30) h = ONE_Q30;
      ys = int_sqrt(longint'(h) << 30);
      xs = int_sqrt(longint'(ONE_Q30 - h) << 30);
      z = vector_phase(longint'(xs), longint'(ys));
      if (z < 0) z = 0;
      if (z > ONE_Q30) z = ONE_Q30;
      cbin = longint'(z) * 2;
      prod = cbin * radius_km;
      hi = prod >> 21;
      lo = prod & ((64'd1 << 21) - 1);
      d = (hi * TWO_PI + ((lo * TWO_PI) >> 21) + (64'd1 << 31)) >> 32;
      dist_km = d[28:0];
   endtask

   task automatic report_mismatch(string what, longint got, longint want);
      $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
      error_count++;
   endtask

   // Present requests from the pending queue; predict on accept
   always @(posedge clock) begin
      logic [28:0] want;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_distance(shown_pair, want);
            expected_dist.push_back(want);
            pairs_sent++;
         end
         if (!req_valid || !req_stall) begin
            if (pending_pairs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               shown_pair = pending_pairs.pop_front();
               req_origin_lat <= shown_pair.olat;
               req_origin_lon <= shown_pair.olon;
               req_dest_lat   <= shown_pair.dlat;
               req_dest_lon   <= shown_pair.dlon;
               req_valid      <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Stall the result channel at random, or hold off for a long stretch
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_cnt  <= 0;
      end else if (hold_start) begin
         hold_cnt  <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_cnt > 0) begin
         hold_cnt  <= hold_cnt - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Compare each accepted distance with the oldest prediction
   always @(posedge clock) begin
      logic [28:0] want;
      if (!reset && rsp_valid && !rsp_stall) begin
         dists_seen++;
         if (expected_dist.size() == 0) begin
            report_mismatch("unexpected distance_km", rsp_distance_km, -1);
         end else begin
            want = expected_dist.pop_front();
            if (rsp_distance_km !== want)
               report_mismatch("distance_km", rsp_distance_km, want);
         end
      end
   end

   // End the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Timeout: no handshake for %0d cycles", STALL_LIMIT);
         $display("Verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic coord_pair_type make_pair(int olat, int olon, int dlat, int dlon);
      coord_pair_type p;
      p.olat = olat[23:0]; p.olon = olon[24:0];
      p.dlat = dlat[23:0]; p.dlon = dlon[24:0];
      return p;
   endfunction

   // Mostly in-range coordinates, some raw full-width values that wrap
   function automatic coord_pair_type random_pair();
      coord_pair_type p;
      if ($urandom_range(9) == 0) begin
         p.olat = 24'($urandom); p.olon = 25'($urandom);
         p.dlat = 24'($urandom); p.dlon = 25'($urandom);
      end else begin
         p.olat = 24'(int'($urandom_range(11796480)) - 5898240);
         p.olon = 25'(int'($urandom_range(23592960)) - 11796480);
         p.dlat = 24'(int'($urandom_range(11796480)) - 5898240);
         p.dlon = 25'(int'($urandom_range(23592960)) - 11796480);
      end
      return p;
   endfunction

   task automatic write_radius(input logic [15:0] value);
      @(posedge clock);
      csr_psel <= 1'b1; csr_penable <= 1'b0; csr_pwrite <= 1'b1;
      csr_paddr <= ADDR_RADIUS; csr_pwdata <= {16'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      radius_km = value;
   endtask

   // Wait until every request is accepted and every distance returned
   task automatic drain();
      do @(negedge clock);
      while (pending_pairs.size() > 0 || req_valid || expected_dist.size() > 0);
      repeat (LATENCY + 8) @(negedge clock);
   endtask

   task automatic queue_random(input int count);
      @(negedge clock);
      for (int i = 0; i < count; i++) pending_pairs.push_back(random_pair());
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed: extremes, identical points, poles, antipodes, wrap
      @(negedge clock);
      pending_pairs.push_back(make_pair(0, 0, 0, 0));
      pending_pairs.push_back(make_pair(5898240, 0, -5898240, 0));
      pending_pairs.push_back(make_pair(-5898240, -11796480, 5898240, 11796480));
      pending_pairs.push_back(make_pair(0, -11796480, 0, 11796480));
      pending_pairs.push_back(make_pair(0, 0, 0, 11796480));
      pending_pairs.push_back(make_pair(0, -11796480, 0, 0));
      pending_pairs.push_back(make_pair(5898240, 0, 5898240, 11796480));
      pending_pairs.push_back(make_pair(1000000, 2000000, 1000000, 2000000));
      pending_pairs.push_back(make_pair(1000000, 2000000, 1000001, 2000001));
      pending_pairs.push_back(make_pair(0, 0, 0, 1));
      pending_pairs.push_back(make_pair(2621440, 655360, -2621440, -11141120));
      pending_pairs.push_back(make_pair(8388607, 16777215, -8388608, -16777216));
      pending_pairs.push_back(make_pair(-8388608, -16777216, 8388607, 16777215));
      pending_pairs.push_back(make_pair(-1, -1, 0, 0));
      pending_pairs.push_back(make_pair(5898240, 11796480, -5898240, -11796480));
      pending_pairs.push_back(make_pair(3000000, -5000000, -2999999, 6796480));
      pending_pairs.push_back(make_pair(0, 11796480, 0, -11796480));
      pending_pairs.push_back(make_pair(-5898240, 0, -5898240, 0));
      drain();

      // Largest radius; sender idles less than receiver
      write_radius(16'hFFFF);
      send_idle_pct = 25; recv_idle_pct = 52;
      queue_random(PHASE_ITEMS);
      drain();

      // Smallest nonzero radius; roles reversed
      write_radius(16'd1);
      send_idle_pct = 52; recv_idle_pct = 25;
      queue_random(PHASE_ITEMS);
      drain();

      // Random radius, no idling, plus a long receiver hold-off
      write_radius(16'($urandom_range(2, 65534)));
      send_idle_pct = 0; recv_idle_pct = 0;
      queue_random(PHASE_ITEMS);
      @(posedge clock);
      hold_start <= 1'b1;
      @(posedge clock);
      hold_start <= 1'b0;
      drain();

      // Zero radius, then back to the reset radius
      write_radius(16'd0);
      queue_random(20);
      drain();
      write_radius(16'd6371);
      queue_random(20);
      drain();

      $display("Sent %0d coordinate pairs, checked %0d distances over radii 6371, 65535, 1,",
               pairs_sent, dists_seen);
      $display("a random radius and 0, with sender and receiver idling and one long hold-off");
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("%0d mismatches", error_count);
         $display("Verification failed");
      end
      $finish;
   end

endmodule
`default_nettype wire

FILE: great_circle_distance_core.f
rtl/core/gcd_pkg.sv
rtl/core/gcd_angle_conv.sv
rtl/core/gcd_rot_cell.sv
rtl/core/gcd_sqrt_cell.sv
rtl/core/gcd_vec_cell.sv
rtl/core/great_circle_distance_core.sv
sim/tb_great_circle_distance_core.sv
